FILE: hw/rtl/vad_pkg.sv
// vad_pkg: shared types, codes and constants of the order-2 ADPCM decoder.
// Used by vad_ctrl, vad_datapath and vadpcm_decoder. No dependencies.
`default_nettype none

package vad_pkg;

  localparam int MAX_PREDICTORS_DEF = 16;
  localparam int SAMPLES_PER_FRAME  = 16;
  localparam int HALF_SAMPLES       = SAMPLES_PER_FRAME / 2;
  localparam int COEFS_PER_PRED     = 16;
  localparam int FRAC_BITS          = 11;

  localparam logic [2:0] LAST_SAMPLE     = 3'(HALF_SAMPLES - 1);
  localparam logic [3:0] FRAME_LEN_BIG   = 4'd9;
  localparam logic [3:0] FRAME_LEN_SMALL = 4'd5;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;
  localparam logic signed [15:0] COEF_ONE   = 16'sd2048;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic {
    CFG_SMALL_MODE = 1'b0,
    CFG_NUM_PRED   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_WAIT  = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    OP_HBL = 2'd0,
    OP_HL  = 2'd1,
    OP_INS = 2'd2
  } opsel_t;

  // one multiply-accumulate term
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    opsel_t     opsel;
    logic       use_const;
    logic [3:0] coef_off;
    logic [2:0] ins_idx;
  } term_cmd_t;

  typedef struct packed {
    logic      take_in;
    term_cmd_t term;
    logic      load_out;
    logic      last_of_half;
    logic      hist6;
  } dp_cmd_t;

  typedef struct packed {
    logic half_ready;
    logic res_valid;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vad_ctrl.sv
// vad_ctrl: sequencer of the decoder; accepts beats and steps the shared MAC
// through the terms of each sample. Depends on vad_pkg.
`default_nettype none

module vad_ctrl
  import vad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] j_r, j_nxt;
  logic [3:0] t_r, t_nxt;
  logic [3:0] last_t;
  logic [3:0] back_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= '0;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      t_r     <= t_nxt;
    end
  end

  assign last_t   = {1'b0, j_r} + 4'd2;
  assign back_off = {1'b0, j_r} + 4'd2 - t_r;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    t_nxt     = t_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.term.opsel = OP_HBL;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.take_in = in_valid;
        if (stat.half_ready) begin
          state_nxt = ST_ISSUE;
          j_nxt     = '0;
          t_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        cmd.term.valid = 1'b1;
        cmd.term.first = (t_r == 4'd0);
        cmd.term.last  = (t_r == last_t);
        case (t_r)
          4'd0: begin
            cmd.term.opsel    = OP_HBL;
            cmd.term.coef_off = {1'b0, j_r};
          end
          4'd1: begin
            cmd.term.opsel    = OP_HL;
            cmd.term.coef_off = {1'b1, j_r};
          end
          4'd2: begin
            cmd.term.opsel     = OP_INS;
            cmd.term.use_const = 1'b1;
            cmd.term.ins_idx   = j_r;
          end
          default: begin
            cmd.term.opsel    = OP_INS;
            cmd.term.ins_idx  = 3'(t_r - 4'd3);
            cmd.term.coef_off = {1'b1, back_off[2:0]};
          end
        endcase
        if (t_r == last_t) begin
          state_nxt = ST_WAIT;
        end else begin
          t_nxt = t_r + 4'd1;
        end
      end
      ST_WAIT: begin
        if (stat.res_valid && stat.out_free) begin
          cmd.load_out     = 1'b1;
          cmd.last_of_half = (j_r == LAST_SAMPLE);
          cmd.hist6        = (j_r == LAST_SAMPLE - 3'd1);
          t_nxt            = '0;
          if (j_r == LAST_SAMPLE) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 3'd1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vad_datapath.sv
// vad_datapath: config registers, codebook RAM, frame tracking, residuals,
// history and the pipelined multiply-accumulate with output register. Uses vad_pkg.
`default_nettype none

module vad_datapath
  import vad_pkg::*;
#(
  parameter int MAX_PREDICTORS = MAX_PREDICTORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_last_of_half,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat
);

  localparam int STORE_DEPTH = MAX_PREDICTORS * COEFS_PER_PRED;
  localparam int AW          = $clog2(STORE_DEPTH);

  // configuration
  logic       small_mode_r;
  logic [4:0] num_pred_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_mode_r <= 1'b0;
      num_pred_r   <= 5'd1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SMALL_MODE) small_mode_r <= cfg_data[0];
      if (cfg_index == CFG_NUM_PRED)   num_pred_r   <= cfg_data;
    end
  end

  // codebook
  logic signed [15:0] coef_mem [STORE_DEPTH];
  logic signed [15:0] coef_rd_r;
  logic [AW-1:0]      rd_addr;
  logic               take_load, take_data, take_start, idx_ok;

  assign take_load  = cmd.take_in && (in_cmd == CMD_LOAD);
  assign take_data  = cmd.take_in && (in_cmd == CMD_DATA);
  assign take_start = cmd.take_in && (in_cmd == CMD_START);
  assign idx_ok     = {1'b0, in_coef_index} < 9'(STORE_DEPTH);

  logic [3:0] pred_sel_r;
  assign rd_addr = AW'({pred_sel_r, cmd.term.coef_off});

  always_ff @(posedge clk) begin
    if (take_load && idx_ok) coef_mem[in_coef_index[AW-1:0]] <= in_coef_value;
    coef_rd_r <= coef_mem[rd_addr];
  end

  // frame tracking
  logic [3:0] shift_r, pos_r, pos_nxt, frame_len, p;
  logic       frame_bad_r, is_header, half_end;
  logic [1:0] jb;

  assign frame_len = small_mode_r ? FRAME_LEN_SMALL : FRAME_LEN_BIG;
  assign is_header = (pos_r == 4'd0) || (pos_r >= frame_len);
  assign p         = pos_r - 4'd1;
  assign jb        = small_mode_r ? {1'b0, p[0]} : p[1:0];
  assign half_end  = (jb == (small_mode_r ? 2'd1 : 2'd3));
  assign pos_nxt   = ((pos_r + 4'd1) >= frame_len) ? 4'd0 : pos_r + 4'd1;

  assign stat.half_ready = take_data && !is_header && half_end && !frame_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      pred_sel_r  <= '0;
      frame_bad_r <= 1'b0;
      pos_r       <= '0;
    end else if (take_start) begin
      pos_r <= '0;
    end else if (take_data) begin
      if (is_header) begin
        shift_r     <= in_data_byte[7:4];
        pred_sel_r  <= in_data_byte[3:0];
        frame_bad_r <= ({1'b0, in_data_byte[3:0]} >= num_pred_r) ||
                       ({1'b0, in_data_byte[3:0]} >= 5'(MAX_PREDICTORS));
        pos_r       <= 4'd1;
      end else begin
        pos_r <= pos_nxt;
      end
    end
  end

  // residual store
  logic [3:0] res_r   [8];
  logic [3:0] res_nxt [8];

  always_comb begin
    for (int e = 0; e < 8; e++) begin
      res_nxt[e] = res_r[e];
      if (take_data && !is_header) begin
        if (small_mode_r) begin
          if ((e / 4) == int'(jb)) res_nxt[e] = {2'b00, 2'(in_data_byte >> (6 - 2 * (e % 4)))};
        end else begin
          if ((e / 2) == int'(jb)) res_nxt[e] = 4'(in_data_byte >> (4 - 4 * (e % 2)));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 8; e++) res_r[e] <= res_nxt[e];
  end

  // history
  logic signed [15:0] hl_r, hbl_r, w6_r, res_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r  <= '0;
      hbl_r <= '0;
    end else if (take_start) begin
      hl_r  <= '0;
      hbl_r <= '0;
    end else if (cmd.load_out && cmd.last_of_half) begin
      hbl_r <= w6_r;
      hl_r  <= res_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out && cmd.hist6) w6_r <= res_sample_r;
  end

  // operand select
  logic [3:0]         rsel;
  logic signed [18:0] ins_base, ins_val, opnd_nxt;

  assign rsel     = res_r[cmd.term.ins_idx];
  assign ins_base = small_mode_r ? 19'(signed'(rsel[1:0])) : 19'(signed'(rsel));
  assign ins_val  = ins_base <<< shift_r;

  always_comb begin
    case (cmd.term.opsel)
      OP_HBL:  opnd_nxt = 19'(hbl_r);
      OP_HL:   opnd_nxt = 19'(hl_r);
      OP_INS:  opnd_nxt = ins_val;
      default: opnd_nxt = '0;
    endcase
  end

  // MAC pipeline
  logic               s1_v_r, s1_first_r, s1_last_r, s1_const_r;
  logic               s2_v_r, s2_first_r, s2_last_r;
  logic signed [18:0] opnd_r;
  logic signed [15:0] mult_coef;
  logic signed [34:0] prod_full;
  logic signed [31:0] prod_r, acc_r, acc_sum;
  logic signed [15:0] sat_val;
  logic               res_valid_r;

  assign mult_coef = s1_const_r ? COEF_ONE : coef_rd_r;
  assign prod_full = mult_coef * opnd_r;
  assign acc_sum   = (s2_first_r ? 32'sd0 : acc_r) + prod_r;

  always_comb begin
    if ((&acc_sum[31:FRAC_BITS+15]) || !(|acc_sum[31:FRAC_BITS+15])) begin
      sat_val = acc_sum[FRAC_BITS+15:FRAC_BITS];
    end else begin
      sat_val = acc_sum[31] ? SAMPLE_MIN : SAMPLE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.term.valid;
      s2_v_r <= s1_v_r;
      if (s2_v_r && s2_last_r) begin
        res_valid_r <= 1'b1;
      end else if (cmd.load_out) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.term.first;
    s1_last_r  <= cmd.term.last;
    s1_const_r <= cmd.term.use_const;
    opnd_r     <= opnd_nxt;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= prod_full[31:0];
    if (s2_v_r) acc_r <= acc_sum;
    if (s2_v_r && s2_last_r) res_sample_r <= sat_val;
  end

  // output register
  logic out_valid_r, out_last_r;
  logic signed [15:0] out_sample_r;

  assign stat.res_valid = res_valid_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= res_sample_r;
      out_last_r   <= cmd.last_of_half;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_last_of_half = out_last_r;

  a_res_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_last_r |-> !res_valid_r)
    else $error("MAC result overwrote an unconsumed sample");

  a_load_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> res_valid_r && stat.out_free)
    else $error("output load without a ready result or free slot");

  a_issue_excludes_intake: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.term.valid |-> !cmd.take_in)
    else $error("beat accepted while MAC terms are issuing");

endmodule

`default_nettype wire

FILE: hw/rtl/vadpcm_decoder.sv
// vadpcm_decoder: top level of the order-2 ADPCM frame decoder.
// Instantiates vad_ctrl and vad_datapath; uses vad_pkg.
//
// A beat that is not the last byte of a half frame is accepted without stalling the input. The
// byte that completes a half of a good frame runs 52 multiply-accumulate
// terms (3 + j for sample j) through one shared 16x19 multiplier fed by the
// codebook RAM, which has one write and one read port. The block takes no
// new beat until the eighth sample of that half is loaded into the output
// register; the samples leave through it and wait there on out_stall.
`default_nettype none

module vadpcm_decoder
  import vad_pkg::*;
#(
  parameter int MAX_PREDICTORS = MAX_PREDICTORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_coef_index,
  input  logic signed [15:0] in_coef_value,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_last_of_half
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  vad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vad_datapath #(
    .MAX_PREDICTORS (MAX_PREDICTORS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_cmd           (in_cmd),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_last_of_half (out_last_of_half),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

`default_nettype wire
